[rtl/dq_pkg.sv]
// ============================================================================
// dq_pkg
// Shared types and constants for the double-ended queue: command and status
// codes, controller states and the result record.
// ============================================================================
package dq_pkg;

   // Fixed field widths of the item channels.
   localparam int DATA_W   = 32;
   localparam int CMD_W    = 3;
   localparam int STATUS_W = 2;
   localparam int COUNT_W  = 5;

   // Word reported when nothing was popped or the queue is empty.
   localparam logic signed [DATA_W-1:0] NO_WORD = '1;

   // Command codes. Codes without a member behave as a query.
   typedef enum logic [CMD_W-1:0] {
      CMD_NONE       = 3'd0,
      CMD_PUSH_FRONT = 3'd1,
      CMD_PUSH_BACK  = 3'd2,
      CMD_POP_FRONT  = 3'd3,
      CMD_POP_BACK   = 3'd4
   } cmd_type;

   // Status codes reported with every result.
   typedef enum logic [STATUS_W-1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Controller states.
   typedef enum logic [1:0] {
      ST_IDLE = 2'd0,
      ST_FILL = 2'd1,
      ST_HOLD = 2'd2
   } state_type;

   // One result item as it travels from the controller to the output stage.
   typedef struct packed {
      logic signed [DATA_W-1:0] popped_value;
      status_type               status;
      logic [COUNT_W-1:0]       entry_count;
      logic                     is_empty;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] back_value;
   } result_type;

endpackage

[rtl/dq_req_if.sv]
// ============================================================================
// dq_req_if
// Command channel of the double-ended queue: valid/ready plus the command
// and the word to push.
// ============================================================================
interface dq_req_if;

   logic                              valid;
   logic                              ready;
   logic [dq_pkg::CMD_W-1:0]          cmd;
   logic signed [dq_pkg::DATA_W-1:0]  push_value;

   modport source (output valid, output cmd, output push_value, input ready);
   modport sink   (input valid, input cmd, input push_value, output ready);

endinterface

[rtl/dq_rsp_if.sv]
// ============================================================================
// dq_rsp_if
// Result channel of the double-ended queue: valid/ready plus the popped word,
// the status and the queue state after the command.
// ============================================================================
interface dq_rsp_if;

   logic                              valid;
   logic                              ready;
   logic signed [dq_pkg::DATA_W-1:0]  popped_value;
   logic [dq_pkg::STATUS_W-1:0]       status;
   logic [dq_pkg::COUNT_W-1:0]        entry_count;
   logic                              is_empty;
   logic signed [dq_pkg::DATA_W-1:0]  front_value;
   logic signed [dq_pkg::DATA_W-1:0]  back_value;

   modport source (output valid, output popped_value, output status,
                   output entry_count, output is_empty, output front_value,
                   output back_value, input ready);
   modport sink   (input valid, input popped_value, input status,
                   input entry_count, input is_empty, input front_value,
                   input back_value, output ready);

endinterface

[rtl/dq_ram.sv]
// ============================================================================
// dq_ram
// Generic single-port-write, single-port-read RAM with a registered read.
// ============================================================================
module dq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Read port, registered.
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/dq_core.sv]
// ============================================================================
// dq_core
// Queue controller: ring pointers, word count, cached front and back words,
// and the slot RAM. A pop that leaves two or more words refills the cache
// from the RAM through the ST_FILL state.
// ============================================================================
module dq_core #(
   parameter int CAPACITY = 16
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [dq_pkg::CMD_W-1:0]          req_cmd,
   input  logic signed [dq_pkg::DATA_W-1:0]  req_push_value,
   input  logic                              out_free,
   output logic                              res_valid,
   output dq_pkg::result_type                res
);

   localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W = $clog2(CAPACITY + 1);

   dq_pkg::state_type               state_ff, state_in;
   logic [IDX_W-1:0]                head_ff, head_in;
   logic [IDX_W-1:0]                tail_ff, tail_in;
   logic [CNT_W-1:0]                count_ff, count_in;
   logic signed [dq_pkg::DATA_W-1:0] front_ff, front_in;
   logic signed [dq_pkg::DATA_W-1:0] back_ff, back_in;
   logic signed [dq_pkg::DATA_W-1:0] popped_ff, popped_in;
   dq_pkg::status_type              status_ff, status_in;
   logic                            fill_front_ff, fill_front_in;

   logic                            accept;
   logic                            need_fill;
   logic                            is_full;
   logic                            is_empty;
   logic [IDX_W-1:0]                head_inc, head_dec;
   logic [IDX_W-1:0]                tail_inc, tail_dec, tail_dec2;

   logic                            wr_en;
   logic [IDX_W-1:0]                wr_addr;
   logic [dq_pkg::DATA_W-1:0]       wr_data;
   logic [IDX_W-1:0]                rd_addr;
   logic [dq_pkg::DATA_W-1:0]       rd_data;

   logic [IDX_W:0]                  ptr_sum;
   logic [IDX_W:0]                  ptr_wrap;

   function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
      return (i == IDX_W'(CAPACITY - 1)) ? '0 : i + IDX_W'(1);
   endfunction

   function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
      return (i == '0) ? IDX_W'(CAPACITY - 1) : i - IDX_W'(1);
   endfunction

   // Slot storage.
   dq_ram #(
      .WIDTH (dq_pkg::DATA_W),
      .DEPTH (CAPACITY)
   ) u_slots (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (need_fill),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // Neighbor indexes of the two ring pointers.
   assign head_inc  = wrap_inc(head_ff);
   assign head_dec  = wrap_dec(head_ff);
   assign tail_inc  = wrap_inc(tail_ff);
   assign tail_dec  = wrap_dec(tail_ff);
   assign tail_dec2 = wrap_dec(tail_dec);

   assign is_full  = (count_ff == CNT_W'(CAPACITY));
   assign is_empty = (count_ff == '0);
   assign accept   = req_valid && req_ready;

   // Command execution: pointer and count update, cache update, RAM access.
   always_comb begin
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      front_in      = front_ff;
      back_in       = back_ff;
      popped_in     = popped_ff;
      status_in     = status_ff;
      fill_front_in = fill_front_ff;
      need_fill     = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = head_dec;
      wr_data       = req_push_value;
      rd_addr       = head_inc;

      // Refill of the cached end word from the RAM read issued last cycle.
      if (state_ff == dq_pkg::ST_FILL) begin
         if (fill_front_ff) begin
            front_in = rd_data;
         end else begin
            back_in = rd_data;
         end
      end

      if (accept) begin
         popped_in = dq_pkg::NO_WORD;
         status_in = dq_pkg::STAT_OK;
         case (dq_pkg::cmd_type'(req_cmd))
            dq_pkg::CMD_PUSH_FRONT: begin
               if (is_full) begin
                  status_in = dq_pkg::STAT_FULL;
               end else begin
                  head_in  = head_dec;
                  count_in = count_ff + CNT_W'(1);
                  front_in = req_push_value;
                  if (is_empty) begin
                     back_in = req_push_value;
                  end
                  wr_en   = 1'b1;
                  wr_addr = head_dec;
               end
            end
            dq_pkg::CMD_PUSH_BACK: begin
               if (is_full) begin
                  status_in = dq_pkg::STAT_FULL;
               end else begin
                  tail_in  = tail_inc;
                  count_in = count_ff + CNT_W'(1);
                  back_in  = req_push_value;
                  if (is_empty) begin
                     front_in = req_push_value;
                  end
                  wr_en   = 1'b1;
                  wr_addr = tail_ff;
               end
            end
            dq_pkg::CMD_POP_FRONT: begin
               if (is_empty) begin
                  status_in = dq_pkg::STAT_EMPTY;
               end else begin
                  popped_in     = front_ff;
                  head_in       = head_inc;
                  count_in      = count_ff - CNT_W'(1);
                  rd_addr       = head_inc;
                  fill_front_in = 1'b1;
                  // With one word left, front and back are the same word.
                  if (count_ff == CNT_W'(2)) begin
                     front_in = back_ff;
                  end else if (count_ff > CNT_W'(2)) begin
                     need_fill = 1'b1;
                  end
               end
            end
            dq_pkg::CMD_POP_BACK: begin
               if (is_empty) begin
                  status_in = dq_pkg::STAT_EMPTY;
               end else begin
                  popped_in     = back_ff;
                  tail_in       = tail_dec;
                  count_in      = count_ff - CNT_W'(1);
                  rd_addr       = tail_dec2;
                  fill_front_in = 1'b0;
                  if (count_ff == CNT_W'(2)) begin
                     back_in = front_ff;
                  end else if (count_ff > CNT_W'(2)) begin
                     need_fill = 1'b1;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            if (accept) begin
               if (need_fill) begin
                  state_in = dq_pkg::ST_FILL;
               end else if (!out_free) begin
                  state_in = dq_pkg::ST_HOLD;
               end
            end
         end
         dq_pkg::ST_FILL: begin
            state_in = out_free ? dq_pkg::ST_IDLE : dq_pkg::ST_HOLD;
         end
         dq_pkg::ST_HOLD: begin
            state_in = out_free ? dq_pkg::ST_IDLE : dq_pkg::ST_HOLD;
         end
         default: begin
            state_in = dq_pkg::ST_IDLE;
         end
      endcase
   end

   // State machine outputs.
   always_comb begin
      req_ready = 1'b0;
      res_valid = 1'b0;
      unique case (state_ff)
         dq_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            res_valid = accept && !need_fill;
         end
         dq_pkg::ST_FILL: begin
            res_valid = 1'b1;
         end
         dq_pkg::ST_HOLD: begin
            res_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // Result record, built from the state after the command.
   always_comb begin
      res.popped_value = popped_in;
      res.status       = status_in;
      res.entry_count  = dq_pkg::COUNT_W'(count_in);
      res.is_empty     = (count_in == '0);
      res.front_value  = (count_in == '0) ? dq_pkg::NO_WORD : front_in;
      res.back_value   = (count_in == '0) ? dq_pkg::NO_WORD : back_in;
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dq_pkg::ST_IDLE;
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Cached words and the pending result fields.
   always_ff @(posedge clock) begin
      front_ff      <= front_in;
      back_ff       <= back_in;
      popped_ff     <= popped_in;
      status_ff     <= status_in;
      fill_front_ff <= fill_front_in;
   end

   // Head plus count, wrapped, must land on the tail.
   assign ptr_sum  = {1'b0, head_ff} + (IDX_W + 1)'(count_ff);
   assign ptr_wrap = (ptr_sum >= (IDX_W + 1)'(CAPACITY)) ?
                     ptr_sum - (IDX_W + 1)'(CAPACITY) : ptr_sum;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(CAPACITY))
      else $error("Word count exceeds the capacity.");

   a_ptr_consistent: assert property (@(posedge clock) disable iff (reset)
      IDX_W'(ptr_wrap) == tail_ff)
      else $error("Head, tail and count disagree.");

   a_push_counts: assert property (@(posedge clock) disable iff (reset)
      accept && !is_full &&
      (req_cmd == dq_pkg::CMD_PUSH_FRONT || req_cmd == dq_pkg::CMD_PUSH_BACK)
      |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("Accepted push did not add one word.");

   a_deep_pop_fills: assert property (@(posedge clock) disable iff (reset)
      accept && count_ff > CNT_W'(2) &&
      (req_cmd == dq_pkg::CMD_POP_FRONT || req_cmd == dq_pkg::CMD_POP_BACK)
      |=> state_ff == dq_pkg::ST_FILL)
      else $error("Pop leaving several words skipped the cache refill.");

endmodule

[rtl/double_ended_queue.sv]
// ============================================================================
// double_ended_queue
// Double-ended queue of signed 32-bit words in a ring buffer of CAPACITY
// slots, one result item for every command item.
// ============================================================================
// Usage:
//   The req channel carries one command per item: query, push front, push
//   back, pop front or pop back, with the word to push. The rsp channel
//   returns one item per command with the popped word (-1 if none), a status
//   (ok, pop on empty, push on full dropped) and the queue state afterward:
//   word count, empty flag, and the front and back words (-1 when empty).
//   The result is registered in the output register before it shows on rsp;
//   a pop that leaves two or more words first passes the ST_FILL state, as
//   its new end word is read from the slot RAM (registered read).
//   Throughput: one item per cycle while the receiver keeps up, except such
//   pops, which hold the next command back until the end word is refilled.
//   A new command is taken while a finished result waits in the output
//   register. If the receiver stalls, the next result is held in the
//   controller and req.ready stays low until the output register frees up.
//   Reset (synchronous, active high) empties the queue at once; slot
//   contents are not cleared and are never read before being written.
// ============================================================================
module double_ended_queue #(
   parameter int CAPACITY = 16
) (
   input  logic     clock,
   input  logic     reset,
   dq_req_if.sink   req,
   dq_rsp_if.source rsp
);

   logic               out_free;
   logic               res_valid;
   dq_pkg::result_type res;
   logic               rsp_valid_ff, rsp_valid_in;
   dq_pkg::result_type rsp_data_ff, rsp_data_in;

   // Queue controller with its slot memory.
   dq_core #(
      .CAPACITY (CAPACITY)
   ) u_core (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req.valid),
      .req_ready      (req.ready),
      .req_cmd        (req.cmd),
      .req_push_value (req.push_value),
      .out_free       (out_free),
      .res_valid      (res_valid),
      .res            (res)
   );

   // Output register: loads a result when empty or being drained.
   assign out_free     = !rsp_valid_ff || rsp.ready;
   assign rsp_valid_in = (res_valid && out_free) || (rsp_valid_ff && !rsp.ready);
   assign rsp_data_in  = (res_valid && out_free) ? res : rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   // Result channel.
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.popped_value = rsp_data_ff.popped_value;
   assign rsp.status       = rsp_data_ff.status;
   assign rsp.entry_count  = rsp_data_ff.entry_count;
   assign rsp.is_empty     = rsp_data_ff.is_empty;
   assign rsp.front_value  = rsp_data_ff.front_value;
   assign rsp.back_value   = rsp_data_ff.back_value;

endmodule
